// ===== hw/rtl/mmpid_pkg.sv =====
// mmpid_pkg: widths, register indexes, mode codes and the register struct
// shared by the multi-mode pid controller files
// no dependencies
`default_nettype none

package mmpid_pkg;

	// payload widths
	localparam int unsigned IN_W       = 24;
	localparam int unsigned ERR_W      = IN_W + 1;
	localparam int unsigned GAIN_W     = 32;
	localparam int unsigned LIM_W      = 31;
	localparam int unsigned RAMP_W     = 24;
	localparam int unsigned MODE_W     = 3;
	localparam int unsigned REG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned DRIVE_W    = 32;

	// fixed point
	localparam int unsigned FRAC_BITS  = 16;
	localparam int unsigned ISUM_W     = 48;

	// shared multiplier: gain magnitude by error-sized magnitude
	localparam int unsigned MUL_A_W    = 32;
	localparam int unsigned MUL_B_W    = 25;
	localparam int unsigned PROD_W     = MUL_A_W + MUL_B_W;

	// integral step and accumulators
	localparam int unsigned STEP_MAG_W = 55;
	localparam int unsigned STEP_W     = STEP_MAG_W + 1;
	localparam int unsigned SUM_W      = STEP_W + 1;
	localparam int unsigned ACC_W      = PROD_W + 1;
	localparam int unsigned Q_W        = ACC_W - FRAC_BITS;

	// ramp divider: remainder preload plus two quotient bits per cycle
	localparam int unsigned QUOT_W     = 56;
	localparam int unsigned DIVD_W     = QUOT_W + RAMP_W;
	localparam int unsigned DIV_STEPS  = QUOT_W / 2;
	localparam int unsigned DIV_CNT_W  = 5;

	localparam logic [RAMP_W-1:0] SEP_EDGE = 24'd500;

	localparam logic [ISUM_W-1:0] ISUM_MAX = {1'b0, {(ISUM_W-1){1'b1}}};
	localparam logic [ISUM_W-1:0] ISUM_MIN = {1'b1, {(ISUM_W-1){1'b0}}};

	// integral rules
	localparam logic [MODE_W-1:0] MODE_PLAIN = 3'd0;
	localparam logic [MODE_W-1:0] MODE_TRAP  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_AW    = 3'd2;
	localparam logic [MODE_W-1:0] MODE_SEP   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_RAMP  = 3'd4;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_MODE      = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_KP        = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_KI        = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_KD        = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_ILIM      = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_OLIM      = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_RAMP_LOW  = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_RAMP_HIGH = 3'd7;

	typedef struct packed {
		logic [MODE_W-1:0]        control_mode;
		logic signed [GAIN_W-1:0] proportional_gain;
		logic signed [GAIN_W-1:0] integral_gain;
		logic signed [GAIN_W-1:0] derivative_gain;
		logic [LIM_W-1:0]         integral_limit;
		logic [LIM_W-1:0]         output_limit;
		logic [RAMP_W-1:0]        ramp_low;
		logic [RAMP_W-1:0]        ramp_high;
	} cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mmpid_if.sv =====
// mmpid channel interfaces: sample input, drive output, register write port
// depends on mmpid_pkg
`default_nettype none

interface mmpid_in_if import mmpid_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic signed [IN_W-1:0] target;
	logic signed [IN_W-1:0] measured;

	modport source (output valid, output target, output measured, input ready);
	modport sink (input valid, input target, input measured, output ready);
endinterface

interface mmpid_out_if import mmpid_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [DRIVE_W-1:0] drive;

	modport source (output valid, output drive, input ready);
	modport sink (input valid, input drive, output ready);
endinterface

interface mmpid_cfg_if import mmpid_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [REG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/mmpid_cfg.sv =====
// mmpid_cfg: register file behind the write port, always ready
// depends on mmpid_pkg and mmpid_if
`default_nettype none

module mmpid_cfg import mmpid_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	mmpid_cfg_if.sink   cfg,
	output cfg_t        regs
);

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_MODE:      regs_q.control_mode      <= cfg.data[MODE_W-1:0];
				REG_KP:        regs_q.proportional_gain <= $signed(cfg.data[GAIN_W-1:0]);
				REG_KI:        regs_q.integral_gain     <= $signed(cfg.data[GAIN_W-1:0]);
				REG_KD:        regs_q.derivative_gain   <= $signed(cfg.data[GAIN_W-1:0]);
				REG_ILIM:      regs_q.integral_limit    <= cfg.data[LIM_W-1:0];
				REG_OLIM:      regs_q.output_limit      <= cfg.data[LIM_W-1:0];
				REG_RAMP_LOW:  regs_q.ramp_low          <= cfg.data[RAMP_W-1:0];
				REG_RAMP_HIGH: regs_q.ramp_high         <= cfg.data[RAMP_W-1:0];
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/mmpid_mul.sv =====
// mmpid_mul: shared unsigned magnitude multiplier with registered product
// depends on mmpid_pkg
`default_nettype none

module mmpid_mul import mmpid_pkg::*; (
	input  logic               clk,
	input  logic [MUL_A_W-1:0] a,
	input  logic [MUL_B_W-1:0] b,
	output logic [PROD_W-1:0]  prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(a) * PROD_W'(b);
	end

endmodule

`default_nettype wire

// ===== hw/rtl/mmpid_div.sv =====
// mmpid_div: restoring divider for the ramp scale, two quotient bits a cycle
// depends on mmpid_pkg; the top bits of the dividend must be below the divisor
`default_nettype none

module mmpid_div import mmpid_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIVD_W-1:0] dividend,
	input  logic [RAMP_W-1:0] divisor,
	output logic              busy,
	output logic [QUOT_W-1:0] quotient
);

	logic                 busy_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [RAMP_W-1:0]    rem_q;
	logic [RAMP_W-1:0]    den_q;
	logic [QUOT_W-1:0]    work_q;

	logic [RAMP_W:0] r1, r1n, r2, r2n;
	logic            ge1, ge2;

	always_comb begin
		r1  = {rem_q, work_q[QUOT_W-1]};
		ge1 = r1 >= {1'b0, den_q};
		r1n = ge1 ? (r1 - {1'b0, den_q}) : r1;
		r2  = {r1n[RAMP_W-1:0], work_q[QUOT_W-2]};
		ge2 = r2 >= {1'b0, den_q};
		r2n = ge2 ? (r2 - {1'b0, den_q}) : r2;
	end

	assign busy     = busy_q;
	assign quotient = work_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DIV_CNT_W'(DIV_STEPS - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// dividend low bits shift out as quotient bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= dividend[DIVD_W-1:QUOT_W];
			work_q <= dividend[QUOT_W-1:0];
			den_q  <= divisor;
		end else if (busy_q) begin
			rem_q  <= r2n[RAMP_W-1:0];
			work_q <= {work_q[QUOT_W-3:0], ge1, ge2};
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/multi_mode_pid_controller_top.sv =====
// multi_mode_pid_controller_top: sequencer around one shared multiplier and the ramp divider
// each input passes error, integral product, trapezoid product (mode 1) or ramp
// products and divider (mode 4 ramp band), integral update unless the integral holds,
// p and d terms, result load; the next input is taken the cycle after the result is loaded
// async reset clears registers, integral sum, last error and the sequencer; the result
// register keeps one finished result while the next item is taken
`default_nettype none

module multi_mode_pid_controller_top import mmpid_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	mmpid_cfg_if.sink    cfg,
	mmpid_in_if.sink     sample,
	mmpid_out_if.source  result
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_ERR  = 4'd1;
	localparam logic [3:0] S_BASE = 4'd2;
	localparam logic [3:0] S_TRAP = 4'd3;
	localparam logic [3:0] S_RLO  = 4'd4;
	localparam logic [3:0] S_RHI  = 4'd5;
	localparam logic [3:0] S_DLD  = 4'd6;
	localparam logic [3:0] S_DIV  = 4'd7;
	localparam logic [3:0] S_INT  = 4'd8;
	localparam logic [3:0] S_P    = 4'd9;
	localparam logic [3:0] S_ACCP = 4'd10;
	localparam logic [3:0] S_ACCD = 4'd11;
	localparam logic [3:0] S_OUT  = 4'd12;

	localparam logic [2:0] PATH_NONE = 3'd0;
	localparam logic [2:0] PATH_BASE = 3'd1;
	localparam logic [2:0] PATH_TRAP = 3'd2;
	localparam logic [2:0] PATH_ZERO = 3'd3;
	localparam logic [2:0] PATH_RAMP = 3'd4;

	cfg_t cfg_regs;

	logic [3:0] state_q, state_d;
	logic [2:0] path_q, path_d;

	logic signed [IN_W-1:0]  target_q, measured_q;
	logic signed [ERR_W-1:0] e_q, last_error_q, e_d;
	logic [RAMP_W-1:0]       e_mag_q, e_mag_d;
	logic [ERR_W-1:0]        e_abs;
	logic [MUL_B_W-1:0]      s_mag_q, de_mag_q, s_mag_d, de_mag_d;
	logic                    s_neg_q, de_neg_q;
	logic [ERR_W:0]          s_w, de_w, s_abs, de_abs;

	logic [MUL_A_W-1:0]      kp_mag, ki_mag, kd_mag;
	logic [MUL_A_W-1:0]      mul_a;
	logic [MUL_B_W-1:0]      mul_b;
	logic [PROD_W-1:0]       prod;

	logic [RAMP_W-1:0]       num, den;
	logic [STEP_MAG_W-1:0]   mbase_q;
	logic [PROD_W-1:0]       lo_q;
	logic [DIVD_W-1:0]       dividend;
	logic                    div_busy;
	logic [QUOT_W-1:0]       quot;

	logic signed [ISUM_W-1:0] isum_q, isum_d, sat_v, lim_s;
	logic [ISUM_W-1:0]        lim_u, isum_mag;
	logic [STEP_MAG_W-1:0]    step_mag;
	logic                     step_neg;
	logic [STEP_W-1:0]        step_s;
	logic [SUM_W-1:0]         sum_w;
	logic                     same_sign, aw_block;

	logic                     term_neg;
	logic [ACC_W-1:0]         term_s, acc_q, acc_mag;
	logic [Q_W-1:0]           q_w;
	logic [LIM_W-1:0]         q_c;
	logic signed [DRIVE_W-1:0] drive_q, drive_d;
	logic                     out_valid_q, out_free;

	mmpid_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (cfg_regs)
	);

	mmpid_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod)
	);

	mmpid_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_DLD),
		.dividend (dividend),
		.divisor  (den),
		.busy     (div_busy),
		.quotient (quot)
	);

	assign sample.ready = (state_q == S_IDLE);
	assign result.valid = out_valid_q;
	assign result.drive = drive_q;
	assign out_free     = !out_valid_q || result.ready;

	// error and its magnitudes
	always_comb begin
		e_d     = {target_q[IN_W-1], target_q} - {measured_q[IN_W-1], measured_q};
		e_abs   = e_d[ERR_W-1] ? (ERR_W'(0) - e_d) : e_d;
		e_mag_d = e_abs[RAMP_W-1:0];
		s_w     = {e_q[ERR_W-1], e_q} + {last_error_q[ERR_W-1], last_error_q};
		de_w    = {e_q[ERR_W-1], e_q} - {last_error_q[ERR_W-1], last_error_q};
		s_abs   = s_w[ERR_W] ? ((ERR_W+1)'(0) - s_w) : s_w;
		de_abs  = de_w[ERR_W] ? ((ERR_W+1)'(0) - de_w) : de_w;
		s_mag_d  = s_abs[MUL_B_W-1:0];
		de_mag_d = de_abs[MUL_B_W-1:0];
	end

	assign kp_mag = cfg_regs.proportional_gain[GAIN_W-1]
		? (MUL_A_W'(0) - cfg_regs.proportional_gain) : cfg_regs.proportional_gain;
	assign ki_mag = cfg_regs.integral_gain[GAIN_W-1]
		? (MUL_A_W'(0) - cfg_regs.integral_gain) : cfg_regs.integral_gain;
	assign kd_mag = cfg_regs.derivative_gain[GAIN_W-1]
		? (MUL_A_W'(0) - cfg_regs.derivative_gain) : cfg_regs.derivative_gain;

	assign num = cfg_regs.ramp_high - e_mag_q;
	assign den = cfg_regs.ramp_high - cfg_regs.ramp_low;

	// high partial product sits in the multiplier register when the divider loads
	assign dividend = {prod[DIVD_W-MUL_A_W-1:0], {MUL_A_W{1'b0}}} + DIVD_W'(lo_q);

	// integral rule for this item
	always_comb begin
		unique case (cfg_regs.control_mode)
			MODE_PLAIN, MODE_AW: path_d = PATH_BASE;
			MODE_TRAP:           path_d = PATH_TRAP;
			MODE_SEP:            path_d = (e_mag_q < SEP_EDGE) ? PATH_BASE : PATH_NONE;
			MODE_RAMP: begin
				if (e_mag_q <= cfg_regs.ramp_low) begin
					path_d = PATH_BASE;
				end else if (e_mag_q > cfg_regs.ramp_high) begin
					path_d = PATH_ZERO;
				end else begin
					path_d = PATH_RAMP;
				end
			end
			default:             path_d = PATH_NONE;
		endcase
	end

	// shared multiplier operands
	always_comb begin
		unique case (state_q)
			S_BASE: begin
				mul_a = ki_mag;
				mul_b = MUL_B_W'(e_mag_q);
			end
			S_TRAP: begin
				mul_a = ki_mag;
				mul_b = s_mag_q;
			end
			S_RLO: begin
				mul_a = prod[MUL_A_W-1:0];
				mul_b = MUL_B_W'(num);
			end
			S_RHI: begin
				mul_a = MUL_A_W'(mbase_q[STEP_MAG_W-1:MUL_A_W]);
				mul_b = MUL_B_W'(num);
			end
			S_P: begin
				mul_a = kp_mag;
				mul_b = MUL_B_W'(e_mag_q);
			end
			S_ACCP: begin
				mul_a = kd_mag;
				mul_b = de_mag_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// integral update
	always_comb begin
		unique case (path_q)
			PATH_BASE: begin
				step_mag = prod[STEP_MAG_W-1:0];
				step_neg = cfg_regs.integral_gain[GAIN_W-1] ^ e_q[ERR_W-1];
			end
			PATH_TRAP: begin
				step_mag = prod[STEP_MAG_W:1];
				step_neg = cfg_regs.integral_gain[GAIN_W-1] ^ s_neg_q;
			end
			PATH_RAMP: begin
				step_mag = quot[STEP_MAG_W-1:0];
				step_neg = cfg_regs.integral_gain[GAIN_W-1] ^ e_q[ERR_W-1];
			end
			default: begin
				step_mag = '0;
				step_neg = 1'b0;
			end
		endcase

		step_s = step_neg ? (STEP_W'(0) - {1'b0, step_mag}) : {1'b0, step_mag};
		sum_w  = {{(SUM_W-ISUM_W){isum_q[ISUM_W-1]}}, isum_q}
		       + {{(SUM_W-STEP_W){step_s[STEP_W-1]}}, step_s};

		// saturate to the integral width
		if ((&sum_w[SUM_W-1:ISUM_W-1]) || !(|sum_w[SUM_W-1:ISUM_W-1])) begin
			sat_v = $signed(sum_w[ISUM_W-1:0]);
		end else if (sum_w[SUM_W-1]) begin
			sat_v = $signed(ISUM_MIN);
		end else begin
			sat_v = $signed(ISUM_MAX);
		end

		lim_u    = ISUM_W'({cfg_regs.integral_limit, {FRAC_BITS{1'b0}}});
		lim_s    = $signed(lim_u);
		isum_mag = isum_q[ISUM_W-1] ? (ISUM_W'(0) - isum_q) : isum_q;

		same_sign = (!isum_q[ISUM_W-1] && (|isum_q) && !e_q[ERR_W-1] && (|e_q))
		         || (isum_q[ISUM_W-1] && e_q[ERR_W-1]);
		aw_block  = (isum_mag > lim_u) && same_sign;

		if (cfg_regs.control_mode == MODE_AW) begin
			isum_d = aw_block ? isum_q : sat_v;
		end else if (sat_v > lim_s) begin
			isum_d = lim_s;
		end else if (sat_v < -lim_s) begin
			isum_d = -lim_s;
		end else begin
			isum_d = sat_v;
		end
	end

	// signed p and d terms, then truncation toward zero and output clamp
	always_comb begin
		term_neg = (state_q == S_ACCP)
			? (cfg_regs.proportional_gain[GAIN_W-1] ^ e_q[ERR_W-1])
			: (cfg_regs.derivative_gain[GAIN_W-1] ^ de_neg_q);
		term_s   = term_neg ? (ACC_W'(0) - {1'b0, prod}) : {1'b0, prod};

		acc_mag  = acc_q[ACC_W-1] ? (ACC_W'(0) - acc_q) : acc_q;
		q_w      = acc_mag[ACC_W-1:FRAC_BITS];
		q_c      = (q_w > Q_W'(cfg_regs.output_limit)) ? cfg_regs.output_limit
		                                               : q_w[LIM_W-1:0];
		drive_d  = acc_q[ACC_W-1] ? (DRIVE_W'(0) - {1'b0, q_c}) : {1'b0, q_c};
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (sample.valid) state_d = S_ERR;
			S_ERR:  state_d = S_BASE;
			S_BASE: begin
				unique case (path_d)
					PATH_BASE, PATH_ZERO: state_d = S_INT;
					PATH_TRAP:            state_d = S_TRAP;
					PATH_RAMP:            state_d = S_RLO;
					default:              state_d = S_P;
				endcase
			end
			S_TRAP: state_d = S_INT;
			S_RLO:  state_d = S_RHI;
			S_RHI:  state_d = S_DLD;
			S_DLD:  state_d = S_DIV;
			S_DIV:  if (!div_busy) state_d = S_INT;
			S_INT:  state_d = S_P;
			S_P:    state_d = S_ACCP;
			S_ACCP: state_d = S_ACCD;
			S_ACCD: state_d = S_OUT;
			S_OUT:  if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			out_valid_q  <= 1'b0;
			isum_q       <= '0;
			last_error_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_INT) begin
				isum_q <= isum_d;
			end
			if (state_q == S_OUT && out_free) begin
				out_valid_q  <= 1'b1;
				last_error_q <= e_q;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			target_q   <= sample.target;
			measured_q <= sample.measured;
		end
		if (state_q == S_ERR) begin
			e_q     <= e_d;
			e_mag_q <= e_mag_d;
		end
		if (state_q == S_BASE) begin
			s_mag_q  <= s_mag_d;
			s_neg_q  <= s_w[ERR_W];
			de_mag_q <= de_mag_d;
			de_neg_q <= de_w[ERR_W];
			path_q   <= path_d;
		end
		if (state_q == S_RLO) begin
			mbase_q <= prod[STEP_MAG_W-1:0];
		end
		if (state_q == S_RHI) begin
			lo_q <= prod;
		end
		if (state_q == S_ACCP) begin
			acc_q <= {{(ACC_W-ISUM_W){isum_q[ISUM_W-1]}}, isum_q} + term_s;
		end else if (state_q == S_ACCD) begin
			acc_q <= acc_q + term_s;
		end
		if (state_q == S_OUT && out_free) begin
			drive_q <= drive_d;
		end
	end

	// clamped rules keep the integral inside the limit
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INT && cfg_regs.control_mode != MODE_AW)
		|=> (isum_q <= $past(lim_s) && isum_q >= -$past(lim_s)))
		else $error("integral sum outside its clamp");

	// a loaded result is valid and within the drive limit
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && out_free)
		|=> (out_valid_q
			&& drive_q <= $signed({1'b0, $past(cfg_regs.output_limit)})
			&& drive_q >= -$signed({1'b0, $past(cfg_regs.output_limit)})))
		else $error("drive result not loaded or beyond limit");

	// the divider starts when the ramp dividend is loaded
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DLD) |=> (div_busy && state_q == S_DIV))
		else $error("ramp divider did not start");

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// testbench for multi_mode_pid_controller_top: directed table, then random register phases
// and sample streams checked against a bit-exact pid predictor with handshake idling
// depends on mmpid_pkg and the mmpid channel interfaces
`default_nettype none

module testbench;
	import mmpid_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 1950;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int SETTLE       = 60;

	localparam longint ISUM_HI = (64'sd1 <<< (ISUM_W - 1)) - 1;
	localparam longint ISUM_LO = -ISUM_HI - 1;

	typedef struct {
		bit                        is_reg;
		logic [REG_IDX_W-1:0]      idx;
		logic [CFG_DATA_W-1:0]     value;
		logic signed [IN_W-1:0]    target;
		logic signed [IN_W-1:0]    measured;
		bit                        known;
		logic signed [DRIVE_W-1:0] drive;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n;

	mmpid_cfg_if cfg_ch ();
	mmpid_in_if  smp_ch ();
	mmpid_out_if res_ch ();

	multi_mode_pid_controller_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.sample (smp_ch),
		.result (res_ch)
	);

	always #5 clk = ~clk;

	// predictor copy of registers and loop state
	cfg_t                      regs_m   = '0;
	logic signed [ERR_W-1:0]   err_prev = '0;
	logic signed [ISUM_W-1:0]  isum_m   = '0;

	logic signed [DRIVE_W-1:0] drive_expected[$];
	plan_row_t                 plan[$];

	// sideband for table rows whose drive is typed in
	bit                        row_known = 1'b0;
	logic signed [DRIVE_W-1:0] row_drive = '0;

	int faults = 0;
	int checked = 0;
	int samples = 0;
	int reg_writes = 0;
	int cycles = 0;
	int burst_left = 0;
	int max_gap = 0;
	logic [7:0] modes_seen = '0;

	function automatic longint mag(input longint v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic longint sat_isum(input longint v);
		if (v > ISUM_HI) return ISUM_HI;
		if (v < ISUM_LO) return ISUM_LO;
		return v;
	endfunction

	function automatic longint integrate(input longint cur, input longint delta, input longint lim);
		longint v;
		v = sat_isum(cur + delta);
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	function automatic void apply_reg(input logic [REG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		case (idx)
			REG_MODE:      regs_m.control_mode      = val[MODE_W-1:0];
			REG_KP:        regs_m.proportional_gain = val[GAIN_W-1:0];
			REG_KI:        regs_m.integral_gain     = val[GAIN_W-1:0];
			REG_KD:        regs_m.derivative_gain   = val[GAIN_W-1:0];
			REG_ILIM:      regs_m.integral_limit    = val[LIM_W-1:0];
			REG_OLIM:      regs_m.output_limit      = val[LIM_W-1:0];
			REG_RAMP_LOW:  regs_m.ramp_low          = val[RAMP_W-1:0];
			REG_RAMP_HIGH: regs_m.ramp_high         = val[RAMP_W-1:0];
			default: ;
		endcase
	endfunction

	// one control update: integral rule, then p + i + d truncated and clamped
	function automatic logic signed [DRIVE_W-1:0] pid_predict(input logic signed [IN_W-1:0] tgt,
			input logic signed [IN_W-1:0] meas);
		longint err, abs_err, prev, ki, base, isum, lim, s, m, num, den, rlow, rhigh;
		longint total, q;
		logic same_sign;
		err     = longint'(tgt) - longint'(meas);
		abs_err = mag(err);
		prev    = longint'(err_prev);
		isum    = longint'(isum_m);
		ki      = longint'($signed(regs_m.integral_gain));
		base    = ki * err;
		lim     = longint'(regs_m.integral_limit) <<< FRAC_BITS;
		if (lim > ISUM_HI) lim = ISUM_HI;
		rlow    = longint'(regs_m.ramp_low);
		rhigh   = longint'(regs_m.ramp_high);
		case (regs_m.control_mode)
			MODE_PLAIN: isum = integrate(isum, base, lim);
			MODE_TRAP: begin
				s = err + prev;
				m = (mag(ki) * mag(s)) >>> 1;
				isum = integrate(isum, ((ki < 0) != (s < 0)) ? -m : m, lim);
			end
			MODE_AW: begin
				same_sign = (isum > 0 && err > 0) || (isum < 0 && err < 0);
				if (!(mag(isum) > lim && same_sign)) isum = sat_isum(isum + base);
			end
			MODE_SEP: begin
				if (abs_err < longint'(SEP_EDGE)) isum = integrate(isum, base, lim);
			end
			MODE_RAMP: begin
				if (abs_err <= rlow) begin
					isum = integrate(isum, base, lim);
				end else if (abs_err > rhigh) begin
					isum = integrate(isum, 0, lim);
				end else begin
					// scaled step truncated toward zero without overflowing the product
					num = rhigh - abs_err;
					den = rhigh - rlow;
					m = mag(base);
					m = (m / den) * num + ((m % den) * num) / den;
					isum = integrate(isum, (base < 0) ? -m : m, lim);
				end
			end
			default: ;
		endcase
		total = longint'($signed(regs_m.proportional_gain)) * err + isum
			+ longint'($signed(regs_m.derivative_gain)) * (err - prev);
		q = mag(total) >>> FRAC_BITS;
		if (q > longint'(regs_m.output_limit)) q = longint'(regs_m.output_limit);
		isum_m   = isum[ISUM_W-1:0];
		err_prev = err[ERR_W-1:0];
		return DRIVE_W'((total < 0) ? -q : q);
	endfunction

	function automatic logic signed [GAIN_W-1:0] pick_gain();
		case ($urandom_range(0, 9))
			0: return {1'b1, {(GAIN_W-1){1'b0}}};
			1: return {1'b0, {(GAIN_W-1){1'b1}}};
			2: return '0;
			3, 4, 5: return $urandom();
			default: return int'($urandom_range(0, 32'h80000)) - 32'sh40000;
		endcase
	endfunction

	function automatic logic [LIM_W-1:0] pick_limit();
		logic [31:0] r;
		r = $urandom();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return {LIM_W{1'b1}};
			2: return r[LIM_W-1:0];
			default: return LIM_W'($urandom_range(0, 200000));
		endcase
	endfunction

	function automatic logic signed [IN_W-1:0] rail_value();
		case ($urandom_range(0, 4))
			0: return {1'b1, {(IN_W-1){1'b0}}};
			1: return {1'b0, {(IN_W-1){1'b1}}};
			2: return '0;
			3: return '1;
			default: return IN_W'(1);
		endcase
	endfunction

	function automatic cfg_t pick_regs(input int phase);
		cfg_t c;
		logic [31:0] r;
		c.control_mode      = MODE_W'($urandom_range(0, 7));
		c.proportional_gain = pick_gain();
		c.integral_gain     = pick_gain();
		c.derivative_gain   = pick_gain();
		c.integral_limit    = pick_limit();
		c.output_limit      = ($urandom_range(0, 3) == 0) ? pick_limit() : {LIM_W{1'b1}};
		r = $urandom();
		case ($urandom_range(0, 9))
			7: begin
				c.ramp_low  = '0;
				c.ramp_high = '1;
			end
			8: begin
				c.ramp_low  = RAMP_W'($urandom_range(0, 1000));
				c.ramp_high = c.ramp_low;
			end
			9: begin
				c.ramp_low  = r[RAMP_W-1:0];
				c.ramp_high = RAMP_W'($urandom());
			end
			// bands near typical errors, inverted now and then
			default: begin
				c.ramp_low  = RAMP_W'($urandom_range(0, 800));
				c.ramp_high = RAMP_W'($urandom_range(0, 2500));
			end
		endcase
		if (phase == 0) begin
			c.control_mode      = MODE_AW;
			c.proportional_gain = {1'b0, {(GAIN_W-1){1'b1}}};
			c.integral_gain     = {1'b0, {(GAIN_W-1){1'b1}}};
			c.derivative_gain   = {1'b1, {(GAIN_W-1){1'b0}}};
			c.integral_limit    = '1;
			c.output_limit      = '1;
			c.ramp_low          = '1;
			c.ramp_high         = '1;
		end else if (phase == 1) begin
			c.control_mode      = MODE_RAMP;
			c.proportional_gain = {1'b1, {(GAIN_W-1){1'b0}}};
			c.integral_gain     = {1'b1, {(GAIN_W-1){1'b0}}};
			c.derivative_gain   = {1'b0, {(GAIN_W-1){1'b1}}};
			c.integral_limit    = '1;
			c.ramp_low          = '0;
			c.ramp_high         = '1;
		end
		return c;
	endfunction

	task automatic reg_row(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		plan_row_t row;
		row = '{1'b1, idx, val, '0, '0, 1'b0, '0};
		plan.push_back(row);
	endtask

	task automatic smp_row(input int tgt, input int meas, input bit known, input int drv);
		plan_row_t row;
		row = '{1'b0, '0, '0, tgt[IN_W-1:0], meas[IN_W-1:0], known, drv};
		plan.push_back(row);
	endtask

	// sender: bursts of transfers separated by random gaps
	task automatic put_sample(input logic signed [IN_W-1:0] tgt,
			input logic signed [IN_W-1:0] meas, input bit known,
			input logic signed [DRIVE_W-1:0] drv);
		int gap;
		if (burst_left == 0) begin
			gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
			repeat (gap) begin
				smp_ch.valid <= 1'b0;
				@(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		smp_ch.valid    <= 1'b1;
		smp_ch.target   <= tgt;
		smp_ch.measured <= meas;
		row_known       <= known;
		row_drive       <= drv;
		do @(posedge clk); while (!smp_ch.ready);
		@(negedge clk);
		burst_left--;
	endtask

	// hold the sender until every pending drive has come back
	task automatic drain();
		smp_ch.valid <= 1'b0;
		burst_left = 0;
		do @(negedge clk); while (drive_expected.size() != 0);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
	endtask

	// all eight registers, with junk above the mode, limit and ramp fields' widths
	task automatic load_regs(input cfg_t c);
		logic [31:0] junk;
		junk = $urandom();
		drain();
		write_reg(REG_MODE, {junk[31:MODE_W], c.control_mode});
		write_reg(REG_KP, c.proportional_gain);
		write_reg(REG_KI, c.integral_gain);
		write_reg(REG_KD, c.derivative_gain);
		write_reg(REG_ILIM, {junk[0], c.integral_limit});
		write_reg(REG_OLIM, {junk[1], c.output_limit});
		write_reg(REG_RAMP_LOW, {junk[9:2], c.ramp_low});
		write_reg(REG_RAMP_HIGH, {junk[17:10], c.ramp_high});
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic make_sample(output logic signed [IN_W-1:0] tgt,
			output logic signed [IN_W-1:0] meas);
		int base, delta, spread, other;
		logic [31:0] r1, r2;
		r1 = $urandom();
		r2 = $urandom();
		case ($urandom_range(0, 9))
			0, 1: begin
				tgt  = r1[IN_W-1:0];
				meas = r2[IN_W-1:0];
			end
			2: begin
				tgt  = rail_value();
				meas = rail_value();
			end
			// tracking loop: measured close to target
			default: begin
				spread = ($urandom_range(0, 3) == 0) ? 40000 : 1200;
				base   = int'($urandom_range(0, 32'hFFFFFF)) - 8388608;
				delta  = int'($urandom_range(0, 2 * spread)) - spread;
				other  = base - delta;
				if (other > 8388607 || other < -8388608) other = base + delta;
				tgt  = base[IN_W-1:0];
				meas = other[IN_W-1:0];
			end
		endcase
	endtask

	// receiver: ready follows one of four patterns, picked anew after each random span
	initial begin : result_taker
		int style, span, k;
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			style = $urandom_range(0, 3);
			span  = $urandom_range(16, 160);
			for (k = 0; k < span; k++) begin
				@(negedge clk);
				case (style)
					0: res_ch.ready <= 1'b1;
					1: res_ch.ready <= ($urandom_range(0, 1) == 1);
					2: res_ch.ready <= (k % 5 == 4);
					default: res_ch.ready <= ((k / 12) % 2 == 1);
				endcase
			end
		end
	end

	always @(posedge clk) begin : drive_check
		logic signed [DRIVE_W-1:0] predicted, wanted;
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				apply_reg(cfg_ch.index, cfg_ch.data);
				reg_writes++;
			end
			if (res_ch.valid && res_ch.ready) begin
				if (drive_expected.size() == 0) begin
					$error("drive: no result pending, got %0d", res_ch.drive);
					faults++;
				end else begin
					wanted = drive_expected.pop_front();
					checked++;
					if (res_ch.drive !== wanted) begin
						$error("drive: expected %0d, got %0d", wanted, res_ch.drive);
						faults++;
					end
				end
			end
			if (smp_ch.valid && smp_ch.ready) begin
				modes_seen[regs_m.control_mode] = 1'b1;
				predicted = pid_predict(smp_ch.target, smp_ch.measured);
				drive_expected.push_back(row_known ? row_drive : predicted);
				samples++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	initial begin
		int i, k, phase, span, pause_at, rnd_sent, directed;
		plan_row_t row;
		logic signed [IN_W-1:0] tgt, meas;
		arst_n          = 1'b0;
		cfg_ch.valid    = 1'b0;
		cfg_ch.index    = '0;
		cfg_ch.data     = '0;
		smp_ch.valid    = 1'b0;
		smp_ch.target   = '0;
		smp_ch.measured = '0;

		// everything zero after reset: drive pinned to zero
		smp_row(8388607, -8388608, 1'b1, 0);
		smp_row(-8388608, 8388607, 1'b1, 0);
		// proportional only, integral held
		reg_row(REG_OLIM, 32'h7FFF_FFFF);
		reg_row(REG_KP, 32'h0001_0000);
		reg_row(REG_MODE, 5);
		smp_row(100, 0, 1'b1, 100);
		smp_row(-8388608, 8388607, 1'b1, -16777215);
		// half gain on a negative error truncates toward zero
		reg_row(REG_KP, 32'h0000_8000);
		smp_row(-3, 0, 1'b1, -1);
		// gain extremes hit the output clamp
		reg_row(REG_KP, 32'h8000_0000);
		smp_row(8388607, -8388608, 1'b1, -2147483647);
		reg_row(REG_KP, 32'h7FFF_FFFF);
		smp_row(-8388608, 8388607, 1'b1, -2147483647);
		smp_row(8388607, -8388608, 1'b1, 2147483647);
		// plain sum running into the integral clamp from both sides
		reg_row(REG_KP, 0);
		reg_row(REG_KI, 32'h0001_0000);
		reg_row(REG_ILIM, 1000);
		reg_row(REG_MODE, MODE_PLAIN);
		smp_row(600, 0, 1'b1, 600);
		smp_row(600, 0, 1'b1, 1000);
		smp_row(-8388608, 8388607, 1'b1, -1000);
		// trapezoid with a negative gain, even and odd sums
		reg_row(REG_MODE, MODE_TRAP);
		reg_row(REG_KI, 32'hFFFF_0000);
		smp_row(3, 0, 1'b0, 0);
		smp_row(-1, 0, 1'b0, 0);
		smp_row(0, 0, 1'b0, 0);
		// anti-windup: same sign over threshold skips, opposite sign steps
		reg_row(REG_MODE, MODE_AW);
		reg_row(REG_KI, 32'h0001_0000);
		reg_row(REG_ILIM, 0);
		smp_row(10, 0, 1'b0, 0);
		smp_row(-5, 0, 1'b0, 0);
		// separation just inside and at the error edge
		reg_row(REG_MODE, MODE_SEP);
		reg_row(REG_ILIM, 100000);
		smp_row(499, 0, 1'b0, 0);
		smp_row(500, 0, 1'b0, 0);
		smp_row(0, 499, 1'b0, 0);
		smp_row(0, 500, 1'b0, 0);
		// ramp: full band, scaled band, top of band, beyond it
		reg_row(REG_MODE, MODE_RAMP);
		reg_row(REG_RAMP_LOW, 100);
		reg_row(REG_RAMP_HIGH, 1000);
		reg_row(REG_KD, 32'h0002_0000);
		smp_row(50, 0, 1'b0, 0);
		smp_row(550, 0, 1'b0, 0);
		smp_row(-1000, 0, 1'b0, 0);
		smp_row(1001, 0, 1'b0, 0);
		// inverted bounds leave no scaled band
		reg_row(REG_RAMP_LOW, 1000);
		reg_row(REG_RAMP_HIGH, 100);
		smp_row(500, 0, 1'b0, 0);
		smp_row(50, 0, 1'b0, 0);
		// hold code 7
		reg_row(REG_MODE, 7);
		smp_row(-700, 300, 1'b0, 0);

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		max_gap = 3;
		directed = 0;
		for (i = 0; i < plan.size(); i++) begin
			row = plan[i];
			if (row.is_reg) begin
				if (i == 0 || !plan[i-1].is_reg) drain();
				write_reg(row.idx, row.value);
				if (i + 1 == plan.size() || !plan[i+1].is_reg) cfg_ch.valid <= 1'b0;
			end else begin
				put_sample(row.target, row.measured, row.known, row.drive);
				directed++;
			end
		end

		phase = 0;
		rnd_sent = 0;
		while (rnd_sent < RANDOM_ITEMS) begin
			load_regs(pick_regs(phase));
			max_gap  = (phase % 4 == 3) ? 0 : $urandom_range(1, 8);
			span     = $urandom_range(40, 160);
			pause_at = $urandom_range(0, span - 1);
			for (k = 0; k < span && rnd_sent < RANDOM_ITEMS; k++) begin
				if (k == pause_at && phase % 2 == 0) drain();
				make_sample(tgt, meas);
				put_sample(tgt, meas, 1'b0, '0);
				rnd_sent++;
			end
			phase++;
		end

		drain();
		repeat (SETTLE) @(posedge clk);
		if (drive_expected.size() != 0) begin
			$error("drive: %0d results never arrived", drive_expected.size());
			faults++;
		end
		$display("summary: %0d samples (%0d from the table), %0d drives checked, %0d failures",
			samples, directed, checked, faults);
		$display("summary: %0d register writes over %0d random phases, rule codes seen %b",
			reg_writes, phase, modes_seen);
		if (faults == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== multi_mode_pid_controller_top.f =====
hw/rtl/mmpid_pkg.sv
hw/rtl/mmpid_if.sv
hw/rtl/mmpid_cfg.sv
hw/rtl/mmpid_mul.sv
hw/rtl/mmpid_div.sv
hw/rtl/multi_mode_pid_controller_top.sv
verif/testbench.sv
